/* sv/lbft_pkg.sv */
// Shared types and constants for the learning bridge forwarding table.
// No dependencies.
package lbft_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int MAC_W         = 48;
    localparam int PORT_W        = 16;
    localparam int TIME_W        = 32;
    localparam int TMO_W         = 17;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(300);

    typedef enum logic [1:0] {
        ACT_FORWARD   = 2'd0,
        ACT_SAME_PORT = 2'd1,
        ACT_FLOOD     = 2'd2,
        ACT_SHORT     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_LEARN,
        ST_AGE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] in_port;
        logic [TIME_W-1:0] now_seconds;
        logic              short_frame;
        logic              same_mac;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } t_entry;

endpackage

/* sv/lbft_front.sv */
// Front end: accepts frame headers, classifies them, queues requests.
// Depends on lbft_pkg.
module lbft_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [lbft_pkg::MAC_W-1:0]  i_src_mac,
    input  logic [lbft_pkg::MAC_W-1:0]  i_dst_mac,
    input  logic [lbft_pkg::PORT_W-1:0] i_in_port,
    input  logic [lbft_pkg::TIME_W-1:0] i_now_seconds,
    input  logic                      i_short_frame,
    output logic                      o_req_valid,
    output lbft_pkg::t_req            o_req,
    input  logic                      i_req_pop
);
    import lbft_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_req       w_in;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_req_pop && o_req_valid;

    always_comb begin
        w_in.src_mac     = i_src_mac;
        w_in.dst_mac     = i_dst_mac;
        w_in.in_port     = i_in_port;
        w_in.now_seconds = i_now_seconds;
        w_in.short_frame = i_short_frame;
        w_in.same_mac    = (i_src_mac == i_dst_mac);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* sv/lbft_engine.sv */
// Back end: table memory, sweep search, learning, aging and result register.
// Depends on lbft_pkg.
module lbft_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lbft_pkg::TMO_W-1:0] i_timeout,
    input  logic                       i_req_valid,
    input  lbft_pkg::t_req             i_req,
    output logic                       o_req_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_action,
    output logic [lbft_pkg::PORT_W-1:0] o_out_port
);
    import lbft_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_chk, n_chk;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_src_hit, n_src_hit;
    logic [IDX_W-1:0] r_src_idx, n_src_idx;
    logic             r_dst_hit, n_dst_hit;
    logic [IDX_W-1:0] r_dst_idx, n_dst_idx;
    logic [PORT_W-1:0] r_dst_port, n_dst_port;
    logic [TIME_W-1:0] r_dst_time, n_dst_time;
    logic             r_free_hit, n_free_hit;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    t_action          r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_action          r_out_act, n_out_act;
    logic [PORT_W-1:0] r_out_port, n_out_port;

    logic             w_rd, w_we, w_out_free;
    logic [IDX_W-1:0] w_raddr, w_waddr;
    t_entry           w_wdata;
    logic [TIME_W-1:0] w_age;

    assign o_valid    = r_out_valid;
    assign o_action   = r_out_act;
    assign o_out_port = r_out_port;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_age      = r_req.now_seconds - r_dst_time;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_rd) r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_src_hit   = r_src_hit;
        n_src_idx   = r_src_idx;
        n_dst_hit   = r_dst_hit;
        n_dst_idx   = r_dst_idx;
        n_dst_port  = r_dst_port;
        n_dst_time  = r_dst_time;
        n_free_hit  = r_free_hit;
        n_free_idx  = r_free_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_stall;
        n_out_act   = r_out_act;
        n_out_port  = r_out_port;
        o_req_pop   = 1'b0;
        w_rd        = 1'b0;
        w_raddr     = r_cnt[IDX_W-1:0];
        w_we        = 1'b0;
        w_waddr     = r_cnt[IDX_W-1:0];
        w_wdata     = '0;

        unique case (r_state)
            ST_CLEAR: begin
                w_we  = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid && w_out_free) begin
                    o_req_pop = 1'b1;
                    if (i_req.short_frame) begin
                        n_out_valid = 1'b1;
                        n_out_act   = ACT_SHORT;
                        n_out_port  = '0;
                    end else begin
                        n_req      = i_req;
                        n_cnt      = '0;
                        n_src_hit  = 1'b0;
                        n_dst_hit  = 1'b0;
                        n_free_hit = 1'b0;
                        n_state    = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_cnt < CNT_W'(TABLE_ENTRIES)) begin
                    w_rd      = 1'b1;
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt[IDX_W-1:0];
                end
                if (r_chk) begin
                    if (r_rdata.valid) begin
                        if (r_rdata.mac == r_req.src_mac) begin
                            n_src_hit = 1'b1;
                            n_src_idx = r_chk_idx;
                        end
                        if (r_rdata.mac == r_req.dst_mac) begin
                            n_dst_hit  = 1'b1;
                            n_dst_idx  = r_chk_idx;
                            n_dst_port = r_rdata.port;
                            n_dst_time = r_rdata.stamp;
                        end
                    end else if (!r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free_idx = r_chk_idx;
                    end
                    if (r_chk_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        n_state = ST_LEARN;
                    end
                end
            end
            ST_LEARN: begin
                w_wdata.valid = 1'b1;
                w_wdata.mac   = r_req.src_mac;
                w_wdata.port  = r_req.in_port;
                w_wdata.stamp = r_req.now_seconds;
                n_state       = ST_DONE;
                if (r_src_hit) begin
                    w_we    = 1'b1;
                    w_waddr = r_src_idx;
                end else if (r_count < CNT_W'(TABLE_ENTRIES) && r_free_hit) begin
                    w_we    = 1'b1;
                    w_waddr = r_free_idx;
                    n_count = r_count + CNT_W'(1);
                end
                priority if (r_req.same_mac) begin
                    n_res = w_we ? ACT_SAME_PORT : ACT_FLOOD;
                end else if (!r_dst_hit) begin
                    n_res = ACT_FLOOD;
                end else if (w_age > TIME_W'(i_timeout)) begin
                    n_res   = ACT_FLOOD;
                    n_state = ST_AGE;
                end else if (r_dst_port == r_req.in_port) begin
                    n_res = ACT_SAME_PORT;
                end else begin
                    n_res = ACT_FORWARD;
                end
            end
            ST_AGE: begin
                w_we    = 1'b1;
                w_waddr = r_dst_idx;
                w_wdata = '0;
                if (n_count != '0) n_count = n_count - CNT_W'(1);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_act   = r_res;
                    n_out_port  = (r_res == ACT_FORWARD) ? r_dst_port : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_chk_idx  <= n_chk_idx;
        r_src_idx  <= n_src_idx;
        r_dst_idx  <= n_dst_idx;
        r_dst_port <= n_dst_port;
        r_dst_time <= n_dst_time;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        r_out_act  <= n_out_act;
        r_out_port <= n_out_port;
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_src_hit   <= 1'b0;
            r_dst_hit   <= 1'b0;
            r_free_hit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_src_hit   <= n_src_hit;
            r_dst_hit   <= n_dst_hit;
            r_free_hit  <= n_free_hit;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* sv/learning_bridge_forwarding_table_core.sv */
// Learning bridge MAC table with aging: timeout register, front queue, engine.
// Short frames get their result registered straight from idle; others sweep every
// table entry, learn the source, delete a stale destination entry if one is found and
// register the result. No new frame is taken until the last result is registered, the
// pace being set by the linear sweep over the single read port of the table; short
// frames one per cycle while the output is not stalled. Reset: synchronous active low;
// a clearing pass over the table follows, during which requests queue unprocessed.
module learning_bridge_forwarding_table_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lbft_pkg::TMO_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lbft_pkg::MAC_W-1:0]  i_src_mac,
    input  logic [lbft_pkg::MAC_W-1:0]  i_dst_mac,
    input  logic [lbft_pkg::PORT_W-1:0] i_in_port,
    input  logic [lbft_pkg::TIME_W-1:0] i_now_seconds,
    input  logic                        i_short_frame,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_action,
    output logic [lbft_pkg::PORT_W-1:0] o_out_port
);
    import lbft_pkg::*;

    logic [TMO_W-1:0] r_timeout;
    logic             w_req_valid, w_req_pop;
    t_req             w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    lbft_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_src_mac     (i_src_mac),
        .i_dst_mac     (i_dst_mac),
        .i_in_port     (i_in_port),
        .i_now_seconds (i_now_seconds),
        .i_short_frame (i_short_frame),
        .o_req_valid   (w_req_valid),
        .o_req         (w_req),
        .i_req_pop     (w_req_pop)
    );

    lbft_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timeout   (r_timeout),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_action    (o_action),
        .o_out_port  (o_out_port)
    );

endmodule

/* dv/learning_bridge_forwarding_table_core_tb.sv */
// Testbench for learning_bridge_forwarding_table_core: directed and random frame headers
// checked against a behavioral MAC table with aging. Depends on lbft_pkg and the core RTL.
`timescale 1ns / 1ps

module learning_bridge_forwarding_table_core_tb;
    import lbft_pkg::*;

    typedef struct {
        logic [MAC_W-1:0]  src;
        logic [MAC_W-1:0]  dst;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
        logic              short_frame;
        logic              typed;
        t_action           act;
        logic [PORT_W-1:0] out_port;
    } t_row;

    typedef struct {
        t_action           act;
        logic [PORT_W-1:0] out_port;
    } t_verdict;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [TMO_W-1:0]    i_cfg_wdata;
    logic                i_valid;
    logic                o_stall;
    logic [MAC_W-1:0]    i_src_mac;
    logic [MAC_W-1:0]    i_dst_mac;
    logic [PORT_W-1:0]   i_in_port;
    logic [TIME_W-1:0]   i_now_seconds;
    logic                i_short_frame;
    logic                o_valid;
    logic                i_stall;
    logic [1:0]          o_action;
    logic [PORT_W-1:0]   o_out_port;

    // behavioral table
    logic                tbl_valid [TABLE_ENTRIES];
    logic [MAC_W-1:0]    tbl_mac   [TABLE_ENTRIES];
    logic [PORT_W-1:0]   tbl_port  [TABLE_ENTRIES];
    logic [TIME_W-1:0]   tbl_stamp [TABLE_ENTRIES];
    int                  tbl_count;
    logic [TMO_W-1:0]    aging_timeout;

    t_verdict            pending_verdicts[$];
    int                  errors;
    int                  requests_sent;
    int                  results_seen;
    bit                  idle_on;
    int                  stall_left;

    logic [MAC_W-1:0]    mac_pool [16];
    logic [PORT_W-1:0]   port_pool [4];
    logic [TIME_W-1:0]   clock_s;

    learning_bridge_forwarding_table_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_src_mac     (i_src_mac),
        .i_dst_mac     (i_dst_mac),
        .i_in_port     (i_in_port),
        .i_now_seconds (i_now_seconds),
        .i_short_frame (i_short_frame),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_out_port    (o_out_port)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int find_mac(logic [MAC_W-1:0] mac);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        end
        return -1;
    endfunction

    function automatic t_verdict forward_lookup(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                                logic [PORT_W-1:0] port, logic [TIME_W-1:0] now,
                                                logic short_frame);
        t_verdict v;
        int s;
        logic [TIME_W-1:0] age;
        v.act = ACT_SHORT;
        v.out_port = '0;
        if (short_frame) return v;
        s = find_mac(src);
        if (s < 0 && tbl_count < TABLE_ENTRIES) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    s = i;
                    break;
                end
            end
            if (s >= 0) begin
                tbl_valid[s] = 1'b1;
                tbl_mac[s] = src;
                tbl_count++;
            end
        end
        if (s >= 0) begin
            tbl_port[s] = port;
            tbl_stamp[s] = now;
        end
        s = find_mac(dst);
        v.act = ACT_FLOOD;
        if (s < 0) return v;
        age = now - tbl_stamp[s];
        if (age > TIME_W'(aging_timeout)) begin
            tbl_valid[s] = 1'b0;
            if (tbl_count > 0) tbl_count--;
            return v;
        end
        if (tbl_port[s] == port) begin
            v.act = ACT_SAME_PORT;
            return v;
        end
        v.act = ACT_FORWARD;
        v.out_port = tbl_port[s];
        return v;
    endfunction

    // leaves i_valid high after the accepting edge; the next frame or idle_input follows
    task automatic send_frame(t_row r);
        t_verdict v;
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_src_mac     <= r.src;
        i_dst_mac     <= r.dst;
        i_in_port     <= r.port;
        i_now_seconds <= r.now;
        i_short_frame <= r.short_frame;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        v = forward_lookup(r.src, r.dst, r.port, r.now, r.short_frame);
        if (r.typed) begin
            v.act = r.act;
            v.out_port = r.out_port;
        end
        pending_verdicts.push_back(v);
        requests_sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic set_timeout(logic [TMO_W-1:0] value);
        idle_input();
        wait (pending_verdicts.size() == 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        aging_timeout = value;
    endtask

    function automatic t_row frame(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                   logic [PORT_W-1:0] port, logic [TIME_W-1:0] now,
                                   logic short_frame);
        t_row r;
        r.src = src;
        r.dst = dst;
        r.port = port;
        r.now = now;
        r.short_frame = short_frame;
        r.typed = 1'b0;
        r.act = ACT_FORWARD;
        r.out_port = '0;
        return r;
    endfunction

    function automatic t_row typed_frame(t_row r, t_action act, logic [PORT_W-1:0] out_port);
        r.typed = 1'b1;
        r.act = act;
        r.out_port = out_port;
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] any_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_row random_frame();
        t_row r;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) clock_s = clock_s + $urandom_range(0, aging_timeout > 400 ? 90000 : 400);
        else if (sel < 80) clock_s = $urandom();
        r = frame(mac_pool[$urandom_range(0, 15)], mac_pool[$urandom_range(0, 15)],
                  port_pool[$urandom_range(0, 3)], clock_s, 1'b0);
        sel = $urandom_range(0, 99);
        if (sel < 6) r.short_frame = 1'b1;
        else if (sel < 12) r.dst = any_mac();
        else if (sel < 16) r.src = any_mac();
        else if (sel < 22) r.port = PORT_W'($urandom());
        else if (sel < 28) r.dst = r.src;
        if ($urandom_range(0, 19) == 0) r.now = $urandom();
        return r;
    endfunction

    // result side: sample at rising edge, stall changes at falling edge
    initial begin
        i_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                results_seen++;
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result action=%0d out_port=%0h", o_action, o_out_port);
                    errors++;
                end else begin
                    t_verdict v;
                    v = pending_verdicts.pop_front();
                    if (o_action !== v.act) begin
                        $error("action: expected %0d, got %0d", v.act, o_action);
                        errors++;
                    end
                    if (o_out_port !== v.out_port) begin
                        $error("out_port: expected %0h, got %0h", v.out_port, o_out_port);
                        errors++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 7) : 0;
            end
            @(negedge i_clk);
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin
        t_row dir_rows[$];
        t_row r;
        logic [TMO_W-1:0] tmo_set[5];

        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        idle_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_src_mac = '0;
        i_dst_mac = '0;
        i_in_port = '0;
        i_now_seconds = '0;
        i_short_frame = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i] = '0;
            tbl_port[i] = '0;
            tbl_stamp[i] = '0;
        end
        tbl_count = 0;
        aging_timeout = TIMEOUT_RESET;
        for (int i = 0; i < 16; i++) mac_pool[i] = any_mac();
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int i = 0; i < 4; i++) port_pool[i] = PORT_W'($urandom());
        port_pool[0] = '0;
        port_pool[1] = '1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset timeout of 300 first
        dir_rows.push_back(typed_frame(frame('1, '1, '1, '1, 1'b1), ACT_SHORT, '0));
        dir_rows.push_back(typed_frame(frame('0, '1, '0, '0, 1'b0), ACT_FLOOD, '0));
        dir_rows.push_back(typed_frame(frame('1, '1, '1, '1, 1'b0), ACT_SAME_PORT, '0));
        dir_rows.push_back(frame(48'h0000_0000_00AA, '0, 16'd5, 32'd10, 1'b0));
        dir_rows.push_back(frame(48'h0000_0000_00BB, 48'h0000_0000_00AA, 16'd7, 32'd310, 1'b0));
        dir_rows.push_back(frame(48'h0000_0000_00BB, 48'h0000_0000_00AA, 16'd7, 32'd311, 1'b0));
        dir_rows.push_back(frame(48'h0000_0000_00BB, 48'h0000_0000_00AA, 16'd7, 32'd312, 1'b0));
        dir_rows.push_back(frame(48'h0000_0000_00CC, 48'h0000_0000_00BB, 16'd9, 32'hFFFF_FFF0,
                                 1'b0));
        dir_rows.push_back(frame(48'h0000_0000_00DD, 48'h0000_0000_00CC, 16'd9, 32'd5, 1'b0));
        dir_rows.push_back(frame(48'h0000_0000_00EE, 48'h0000_0000_00CC, 16'd3, 32'd6, 1'b0));
        dir_rows.push_back(frame(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5555,
                                 32'h5555_5555, 1'b0));
        dir_rows.push_back(frame(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA,
                                 32'hAAAA_AAAA, 1'b0));
        dir_rows.push_back(typed_frame(frame('0, '0, '0, '0, 1'b1), ACT_SHORT, '0));
        foreach (dir_rows[i]) send_frame(dir_rows[i]);

        // zero timeout: any age of one second is stale
        set_timeout('0);
        send_frame(frame(48'h0000_0000_0011, 48'h0000_0000_0022, 16'd1, 32'd100, 1'b0));
        send_frame(frame(48'h0000_0000_0022, 48'h0000_0000_0011, 16'd2, 32'd100, 1'b0));
        send_frame(frame(48'h0000_0000_0022, 48'h0000_0000_0011, 16'd2, 32'd101, 1'b0));
        set_timeout('1);
        send_frame(frame(48'h0000_0000_0033, 48'h0000_0000_0022, 16'd4, 32'd131172, 1'b0));
        send_frame(frame(48'h0000_0000_0033, 48'h0000_0000_0022, 16'd4, 32'd131173, 1'b0));

        // random phases over several timeouts
        tmo_set[0] = 17'd30;
        tmo_set[1] = 17'd300;
        tmo_set[2] = 17'd86400;
        tmo_set[3] = '0;
        tmo_set[4] = TMO_W'($urandom());
        clock_s = $urandom();
        for (int ph = 0; ph < 5; ph++) begin
            set_timeout(tmo_set[ph]);
            idle_on = (ph != 2);
            for (int i = 0; i < 60; i++) send_frame(random_frame());
        end

        // fill the table with fresh sources, then keep sending unknown sources
        set_timeout('1);
        idle_on = 1'b1;
        for (int i = 0; i < TABLE_ENTRIES + 40; i++) begin
            r = random_frame();
            r.src = {16'hC0DE, 32'(i)};
            r.short_frame = ($urandom_range(0, 49) == 0);
            if (i % 3 == 0) r.dst = {16'hC0DE, 32'($urandom_range(0, i))};
            send_frame(r);
        end
        idle_input();

        wait (pending_verdicts.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d frame headers (%0d results) across five timeout settings,",
                 requests_sent, results_seen);
        $display("aging, wraparound, same-port drops, short frames and a full table.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
